// ===== rtl/ppt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and codes for the pausable periodic timer: item kinds,
// result status codes and timer states.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int unsigned CountW = 32;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_START      = 3'd1,
        KIND_STOP       = 3'd2,
        KIND_PAUSE      = 3'd3,
        KIND_RESUME     = 3'd4,
        KIND_SET_PERIOD = 3'd5,
        KIND_QUERY      = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_INVALID     = 3'd1,
        STATUS_ALREADY     = 3'd2,
        STATUS_NOT_RUNNING = 3'd3,
        STATUS_NOT_PAUSED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TS_STOPPED = 2'd0,
        TS_RUNNING = 2'd1,
        TS_PAUSED  = 2'd2
    } timer_state_t;

endpackage : ppt_pkg
`default_nettype wire

// ===== rtl/pausable_periodic_timer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pausable_periodic_timer_unit
// Stopped / running / paused countdown timer driven by command and tick
// transactions, with one result transaction per input transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  cfg     | cfg_valid, cfg_ready | cfg_data (periodic_mode)
//  in      | in_valid, in_ready   | kind, new_period, restart_running
//  out     | out_valid, out_ready | status, fired, run_state, remaining_ticks,
//          |                      | current_period
//
//  An accepted item is loaded into the input register, then passes through
//  the update logic into the result register, which drives out_valid.
//  Throughput is one transaction per cycle while out is not stalled; the
//  timer state registers are read and written in the same stage, so each
//  item sees its predecessor.
//  Reset leaves the timer stopped with zero period, periodic mode set.
//  A stall on out holds the result register and the input register; in_ready
//  drops only when both are full and out_ready is low.
// ----------------------------------------------------------------------------
module pausable_periodic_timer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] new_period,
    input  wire logic        restart_running,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             fired,
    output logic [1:0]       run_state,
    output logic [31:0]      remaining_ticks,
    output logic [31:0]      current_period
);

    // Configuration
    logic periodic_mode_reg;

    // Input register
    logic                     in_valid_reg;
    ppt_pkg::kind_t           kind_reg;
    logic [ppt_pkg::CountW-1:0] new_period_reg;
    logic                     restart_reg;

    // Timer state
    ppt_pkg::timer_state_t      timer_state_reg, timer_state_next;
    logic [ppt_pkg::CountW-1:0] countdown_reg, countdown_next;
    logic [ppt_pkg::CountW-1:0] saved_reg, saved_next;
    logic [ppt_pkg::CountW-1:0] period_reg, period_next;

    // Result register
    logic                       out_valid_reg;
    ppt_pkg::status_t           status_reg, status_next;
    logic                       fired_reg, fired_next;
    ppt_pkg::timer_state_t      run_state_reg;
    logic [ppt_pkg::CountW-1:0] remaining_reg, remaining_next;
    logic [ppt_pkg::CountW-1:0] cur_period_reg;

    logic advance;
    logic [ppt_pkg::CountW-1:0] resume_load;

    // Result stage may load when empty or when its transaction leaves now
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            periodic_mode_reg <= cfg_data;
        end
    end

    // Input register: hold while the result stage is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg       <= ppt_pkg::kind_t'(kind);
            new_period_reg <= new_period;
            restart_reg    <= restart_running;
        end
    end

    assign resume_load = (saved_reg != '0) ? saved_reg : period_reg;

    // Update logic: one item against the current timer state
    always_comb
    begin
        timer_state_next = timer_state_reg;
        countdown_next   = countdown_reg;
        saved_next       = saved_reg;
        period_next      = period_reg;
        status_next      = ppt_pkg::STATUS_OK;
        fired_next       = 1'b0;

        unique case (kind_reg)
            ppt_pkg::KIND_TICK:
            begin
                if (timer_state_reg == ppt_pkg::TS_RUNNING)
                begin
                    if (countdown_reg > ppt_pkg::CountW'(1))
                    begin
                        countdown_next = countdown_reg - ppt_pkg::CountW'(1);
                    end
                    else
                    begin
                        fired_next = 1'b1;
                        if (periodic_mode_reg && (period_reg != '0))
                        begin
                            countdown_next = period_reg;
                        end
                        else
                        begin
                            timer_state_next = ppt_pkg::TS_STOPPED;
                            countdown_next   = '0;
                            saved_next       = '0;
                        end
                    end
                end
            end
            ppt_pkg::KIND_START:
            begin
                if (timer_state_reg == ppt_pkg::TS_RUNNING)
                begin
                    status_next = ppt_pkg::STATUS_ALREADY;
                end
                else if (period_reg == '0)
                begin
                    status_next = ppt_pkg::STATUS_INVALID;
                end
                else
                begin
                    timer_state_next = ppt_pkg::TS_RUNNING;
                    saved_next       = '0;
                    countdown_next   = period_reg;
                end
            end
            ppt_pkg::KIND_STOP:
            begin
                if (timer_state_reg == ppt_pkg::TS_STOPPED)
                begin
                    status_next = ppt_pkg::STATUS_NOT_RUNNING;
                end
                else
                begin
                    timer_state_next = ppt_pkg::TS_STOPPED;
                    countdown_next   = '0;
                    saved_next       = '0;
                end
            end
            ppt_pkg::KIND_PAUSE:
            begin
                if (timer_state_reg != ppt_pkg::TS_RUNNING)
                begin
                    status_next = ppt_pkg::STATUS_NOT_RUNNING;
                end
                else
                begin
                    saved_next = (countdown_reg == '0) ? ppt_pkg::CountW'(1)
                                                       : countdown_reg;
                    countdown_next   = '0;
                    timer_state_next = ppt_pkg::TS_PAUSED;
                end
            end
            ppt_pkg::KIND_RESUME:
            begin
                if (timer_state_reg != ppt_pkg::TS_PAUSED)
                begin
                    status_next = ppt_pkg::STATUS_NOT_PAUSED;
                end
                else if (resume_load == '0)
                begin
                    status_next = ppt_pkg::STATUS_INVALID;
                end
                else
                begin
                    timer_state_next = ppt_pkg::TS_RUNNING;
                    saved_next       = '0;
                    countdown_next   = resume_load;
                end
            end
            ppt_pkg::KIND_SET_PERIOD:
            begin
                if (new_period_reg == '0)
                begin
                    status_next = ppt_pkg::STATUS_INVALID;
                end
                else
                begin
                    period_next = new_period_reg;
                    if (restart_reg && (timer_state_reg == ppt_pkg::TS_RUNNING))
                    begin
                        countdown_next = new_period_reg;
                    end
                end
            end
            default:
            begin
                // query and the unused code: report only
            end
        endcase

        unique case (timer_state_next)
            ppt_pkg::TS_RUNNING: remaining_next = countdown_next;
            ppt_pkg::TS_PAUSED:  remaining_next = saved_next;
            default:             remaining_next = '0;
        endcase
    end

    // Timer state: advance only when an item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_state_reg <= ppt_pkg::TS_STOPPED;
            countdown_reg   <= '0;
            saved_reg       <= '0;
            period_reg      <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            timer_state_reg <= timer_state_next;
            countdown_reg   <= countdown_next;
            saved_reg       <= saved_next;
            period_reg      <= period_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            status_reg     <= status_next;
            fired_reg      <= fired_next;
            run_state_reg  <= timer_state_next;
            remaining_reg  <= remaining_next;
            cur_period_reg <= period_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign fired           = fired_reg;
    assign run_state       = run_state_reg;
    assign remaining_ticks = remaining_reg;
    assign current_period  = cur_period_reg;

`ifndef SYNTHESIS
    // Stopped timer holds no count
    a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (timer_state_reg == ppt_pkg::TS_STOPPED)
            |-> (countdown_reg == '0) && (saved_reg == '0))
        else $error("stopped timer holds a count");

    // Paused timer keeps a non-zero saved count and no live countdown
    a_paused_saved: assert property (@(posedge clk) disable iff (!rst_n)
        (timer_state_reg == ppt_pkg::TS_PAUSED)
            |-> (countdown_reg == '0) && (saved_reg != '0))
        else $error("paused timer state inconsistent");

    // Running timer always has a live countdown and no saved count
    a_running_live: assert property (@(posedge clk) disable iff (!rst_n)
        (timer_state_reg == ppt_pkg::TS_RUNNING)
            |-> (countdown_reg != '0) && (saved_reg == '0))
        else $error("running timer state inconsistent");

    // An expiry is always a successful tick and never leaves the timer paused
    a_fired_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fired_reg)
            |-> (status_reg == ppt_pkg::STATUS_OK)
                && (run_state_reg != ppt_pkg::TS_PAUSED))
        else $error("firing result inconsistent");
`endif

endmodule : pausable_periodic_timer_unit
`default_nettype wire

// ===== sim/tb_pausable_periodic_timer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_pausable_periodic_timer_unit
// Self-checking bench for the pausable periodic timer. A short table of
// directed transactions opens the run, then five phases of weighted random
// commands and ticks follow, alternating periodic and one-shot mode. Every
// result is checked field by field against an in-bench timer predictor or a
// pinned one. Random back-pressure and input gaps apply but for the calm phase.
// ----------------------------------------------------------------------------
module tb_pausable_periodic_timer_unit;

    // The one kind code that the package leaves unnamed; it must act as a query.
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam int unsigned NUM_ROWS       = 26;
    localparam int unsigned NUM_PHASES     = 5;
    localparam int unsigned PHASE_ITEMS    = 340;
    localparam int unsigned PIPE_LATENCY   = 2;
    // Cycles without any transaction before the run is declared hung. The
    // limit sits well above any honest gap from stalls and input gaps.
    localparam int unsigned STALL_LIMIT    = 1000;

    typedef struct packed {
        ppt_pkg::status_t      status;
        logic                  fired;
        ppt_pkg::timer_state_t run_state;
        logic [31:0]           remaining;
        logic [31:0]           period;
    } timer_result_t;

    typedef struct packed {
        logic          set_mode;   // drain and rewrite periodic_mode first
        logic          mode;
        logic [2:0]    kind;
        logic [31:0]   period_arg;
        logic          restart;
        logic          pinned;     // use the typed-in result below
        timer_result_t want;
    } directed_row_t;

    localparam timer_result_t NO_PIN = '0;

    // Directed opening: error codes from reset, period extremes, pause and
    // resume, firing with reload, then a one-shot expiry.
    localparam directed_row_t PLAN [NUM_ROWS] = '{
        '{1'b0, 1'b0, ppt_pkg::KIND_QUERY, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_OK, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_OK, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_START, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_INVALID, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_STOP, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_NOT_RUNNING, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_PAUSE, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_NOT_RUNNING, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_RESUME, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_NOT_PAUSED, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_SET_PERIOD, 32'h0, 1'b1, 1'b1,
          '{ppt_pkg::STATUS_INVALID, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'h0}},
        '{1'b0, 1'b0, ppt_pkg::KIND_SET_PERIOD, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{ppt_pkg::STATUS_OK, 1'b0, ppt_pkg::TS_STOPPED, 32'h0, 32'hFFFF_FFFF}},
        '{1'b0, 1'b0, ppt_pkg::KIND_START, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_OK, 1'b0, ppt_pkg::TS_RUNNING, 32'hFFFF_FFFF,
            32'hFFFF_FFFF}},
        '{1'b0, 1'b0, ppt_pkg::KIND_START, 32'h0, 1'b0, 1'b1,
          '{ppt_pkg::STATUS_ALREADY, 1'b0, ppt_pkg::TS_RUNNING, 32'hFFFF_FFFF,
            32'hFFFF_FFFF}},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_SET_PERIOD, 32'h3, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_SET_PERIOD, 32'h2, 1'b1, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_PAUSE, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_RESUME, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_PAUSE, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_START, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, KIND_UNUSED, 32'hA5A5_5A5A, 1'b1, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_STOP, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b1, 1'b0, ppt_pkg::KIND_SET_PERIOD, 32'h1, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_START, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_TICK, 32'h0, 1'b0, 1'b0, NO_PIN},
        '{1'b0, 1'b0, ppt_pkg::KIND_QUERY, 32'h0, 1'b0, 1'b0, NO_PIN}
    };

    // periodic_mode for each random phase; both values, ending periodic
    localparam logic PHASE_MODE [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [31:0] new_period;
    logic        restart_running;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        fired;
    logic [1:0]  run_state;
    logic [31:0] remaining_ticks;
    logic [31:0] current_period;

    // Predicted timer state, advanced once per accepted input transaction
    logic                  mode_q;
    ppt_pkg::timer_state_t timer_q;
    logic [31:0]           countdown_q;
    logic [31:0]           saved_q;
    logic [31:0]           period_q;

    timer_result_t expected_results [$];
    timer_result_t pinned_result;
    logic          pinned_row;
    logic          calm;          // no gaps and no back-pressure while set
    int unsigned   mismatches;

    pausable_periodic_timer_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .new_period      (new_period),
        .restart_running (restart_running),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .fired           (fired),
        .run_state       (run_state),
        .remaining_ticks (remaining_ticks),
        .current_period  (current_period)
    );

    always #5 clk = ~clk;

    // Back-pressure on the result channel, lifted during the calm phase
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    // Advance the predicted timer by one transaction and return its result
    task automatic step_timer(input logic [2:0] k, input logic [31:0] np,
                              input logic rs, output timer_result_t r);
        logic [31:0] load;
        r.status = ppt_pkg::STATUS_OK;
        r.fired  = 1'b0;
        unique case (k)
            ppt_pkg::KIND_TICK:
                if (timer_q == ppt_pkg::TS_RUNNING)
                begin
                    if (countdown_q > 32'd1)
                        countdown_q = countdown_q - 32'd1;
                    else
                    begin
                        r.fired = 1'b1;
                        if (mode_q && period_q != 32'd0)
                            countdown_q = period_q;
                        else
                        begin
                            timer_q     = ppt_pkg::TS_STOPPED;
                            countdown_q = '0;
                            saved_q     = '0;
                        end
                    end
                end
            ppt_pkg::KIND_START:
                if (timer_q == ppt_pkg::TS_RUNNING)
                    r.status = ppt_pkg::STATUS_ALREADY;
                else if (period_q == 32'd0)
                    r.status = ppt_pkg::STATUS_INVALID;
                else
                begin
                    timer_q     = ppt_pkg::TS_RUNNING;
                    saved_q     = '0;
                    countdown_q = period_q;
                end
            ppt_pkg::KIND_STOP:
                if (timer_q == ppt_pkg::TS_STOPPED)
                    r.status = ppt_pkg::STATUS_NOT_RUNNING;
                else
                begin
                    timer_q     = ppt_pkg::TS_STOPPED;
                    countdown_q = '0;
                    saved_q     = '0;
                end
            ppt_pkg::KIND_PAUSE:
                if (timer_q != ppt_pkg::TS_RUNNING)
                    r.status = ppt_pkg::STATUS_NOT_RUNNING;
                else
                begin
                    // hold at least one tick so that resume has work to do
                    saved_q     = (countdown_q == 32'd0) ? 32'd1 : countdown_q;
                    countdown_q = '0;
                    timer_q     = ppt_pkg::TS_PAUSED;
                end
            ppt_pkg::KIND_RESUME:
                if (timer_q != ppt_pkg::TS_PAUSED)
                    r.status = ppt_pkg::STATUS_NOT_PAUSED;
                else
                begin
                    load = (saved_q != 32'd0) ? saved_q : period_q;
                    if (load == 32'd0)
                        r.status = ppt_pkg::STATUS_INVALID;
                    else
                    begin
                        timer_q     = ppt_pkg::TS_RUNNING;
                        saved_q     = '0;
                        countdown_q = load;
                    end
                end
            ppt_pkg::KIND_SET_PERIOD:
                if (np == 32'd0)
                    r.status = ppt_pkg::STATUS_INVALID;
                else
                begin
                    period_q = np;
                    if (rs && timer_q == ppt_pkg::TS_RUNNING)
                        countdown_q = np;
                end
            default: ;
        endcase
        r.run_state = timer_q;
        r.remaining = (timer_q == ppt_pkg::TS_RUNNING) ? countdown_q :
                      (timer_q == ppt_pkg::TS_PAUSED)  ? saved_q : 32'd0;
        r.period    = period_q;
    endtask

    // Sample every channel at the rising edge: record configuration first,
    // then check results, then record input transactions. Hold the predictor at
    // its reset state while rst_n is low.
    always @(posedge clk)
    begin : scoreboard
        timer_result_t want;
        timer_result_t predicted;
        if (!rst_n)
        begin
            mode_q      = 1'b1;
            timer_q     = ppt_pkg::TS_STOPPED;
            countdown_q = '0;
            saved_q     = '0;
            period_q    = '0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_q = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result with nothing expected", 32'(status), '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status != want.status)
                        note_mismatch("status", 32'(status), 32'(want.status));
                    if (fired != want.fired)
                        note_mismatch("fired", 32'(fired), 32'(want.fired));
                    if (run_state != want.run_state)
                        note_mismatch("run_state", 32'(run_state),
                                      32'(want.run_state));
                    if (remaining_ticks != want.remaining)
                        note_mismatch("remaining_ticks", remaining_ticks, want.remaining);
                    if (current_period != want.period)
                        note_mismatch("current_period", current_period, want.period);
                end
            end
            if (in_valid && in_ready)
            begin
                step_timer(kind, new_period, restart_running, predicted);
                expected_results.push_back(pinned_row ? pinned_result : predicted);
            end
        end
    end

    // Offer one transaction, with a random gap in front unless calm
    task automatic offer_item(input logic [2:0] k, input logic [31:0] np,
                              input logic rs, input logic pin,
                              input timer_result_t pin_want);
        @(negedge clk);
        if (!calm)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        pinned_row      = pin;
        pinned_result   = pin_want;
        in_valid        <= 1'b1;
        kind            <= k;
        new_period      <= np;
        restart_running <= rs;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold off until every outstanding result has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Called on a falling edge with the timer idle
    task automatic write_mode(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Abandon the run if nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0]  k;
        logic [31:0] np;
        logic        rs;
        int unsigned roll;

        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        in_valid        = 1'b0;
        kind            = ppt_pkg::KIND_QUERY;
        new_period      = '0;
        restart_running = 1'b0;
        calm            = 1'b0;
        pinned_row      = 1'b0;
        pinned_result   = NO_PIN;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (PLAN[i])
        begin
            if (PLAN[i].set_mode)
            begin
                drain_results();
                write_mode(PLAN[i].mode);
            end
            offer_item(PLAN[i].kind, PLAN[i].period_arg, PLAN[i].restart,
                       PLAN[i].pinned, PLAN[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_mode(PHASE_MODE[p]);
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause the sender mid-phase until the pipeline is empty
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                // ticks dominate so that countdowns expire often
                roll = $urandom_range(99);
                if (roll < 50)
                    k = ppt_pkg::KIND_TICK;
                else if (roll < 58)
                    k = ppt_pkg::KIND_START;
                else if (roll < 64)
                    k = ppt_pkg::KIND_STOP;
                else if (roll < 72)
                    k = ppt_pkg::KIND_PAUSE;
                else if (roll < 80)
                    k = ppt_pkg::KIND_RESUME;
                else if (roll < 92)
                    k = ppt_pkg::KIND_SET_PERIOD;
                else if (roll < 97)
                    k = ppt_pkg::KIND_QUERY;
                else
                    k = KIND_UNUSED;
                // mostly short periods, with zero, full-range and near-max values
                roll = $urandom_range(99);
                if (roll < 70)
                    np = $urandom_range(8, 1);
                else if (roll < 78)
                    np = '0;
                else if (roll < 90)
                    np = $urandom;
                else
                    np = 32'hFFFF_FFFF - $urandom_range(3);
                rs = 1'($urandom_range(1));
                offer_item(k, np, rs, 1'b0, NO_PIN);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
